>>> rtl/acrq_pkg.sv
// acrq_pkg: shared types and codes for the accumulator requantizer.
// Holds register indexes, activation codes and the configuration struct.
// No dependencies.
package acrq_pkg;

	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W = 2;
	localparam int BIAS_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_ACT_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_SHIFT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_SHIFT = 2'd2;

	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_RELU = 2'd1;
	localparam logic [1:0] ACT_LEAKY = 2'd2;

	localparam logic [6:0] LEAKY_EXTRA_SHIFT = 7'd3;

	typedef struct packed {
		logic [1:0] act_mode;
		logic [6:0] output_shift;
		logic [5:0] bias_shift;
	} cfg_t;

endpackage

>>> rtl/acrq_datapath.sv
// acrq_datapath: four-stage requantize pipeline (saturate and bias scale,
// bias add and activation, rounding shift, int16 saturation).
// Depends on acrq_pkg.
module acrq_datapath #(
	parameter int ACC_BITS = 40
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic signed [63:0]  acc_sum,
	input  logic signed [15:0]  bias_value,
	input  acrq_pkg::cfg_t      cfg,
	output logic                out_valid,
	output logic signed [15:0]  out_value
);

	localparam int BW = acrq_pkg::BIAS_W;
	localparam int ADD_W = ((ACC_BITS > BW) ? ACC_BITS : BW) + 1;
	localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

	logic v_s1, v_s2, v_s3, v_s4;

	logic [ACC_BITS-1:0] acc_s1;
	logic [BW-1:0]       bias_s1;
	logic [ACC_BITS-1:0] x_s2;
	logic [6:0]          sh_s2;
	logic [ACC_BITS:0]   t_s3;
	logic [15:0]         out_s4;

	// stage 1 logic
	logic [64-ACC_BITS:0] acc_hi;
	logic [ACC_BITS-1:0]  acc_sat;
	logic signed [BW-1:0] bias_ext;
	logic signed [BW-1:0] bias_sc;
	logic [5:0]           lsh;

	always_comb begin
		acc_hi = acc_sum[63:ACC_BITS-1];
		if ((&acc_hi) || !(|acc_hi)) begin
			acc_sat = acc_sum[ACC_BITS-1:0];
		end else if (acc_sum[63]) begin
			acc_sat = ACC_MIN;
		end else begin
			acc_sat = ACC_MAX;
		end
		bias_ext = {{(BW-16){bias_value[15]}}, bias_value};
		lsh = 6'(~cfg.bias_shift + 6'd1);
		if (cfg.bias_shift[5]) begin
			bias_sc = bias_ext <<< lsh;
		end else begin
			bias_sc = bias_ext >>> cfg.bias_shift[4:0];
		end
	end

	// stage 2 logic
	logic [ADD_W-1:0]        sum;
	logic [ADD_W-ACC_BITS:0] sum_hi;
	logic [ACC_BITS-1:0]     sum_sat;
	logic [ACC_BITS-1:0]     act_val;
	logic [6:0]              sh_base;
	logic [6:0]              sh_val;
	logic                    neg;

	always_comb begin
		sum = {{(ADD_W-ACC_BITS){acc_s1[ACC_BITS-1]}}, acc_s1}
			+ {{(ADD_W-BW){bias_s1[BW-1]}}, bias_s1};
		sum_hi = sum[ADD_W-1:ACC_BITS-1];
		if ((&sum_hi) || !(|sum_hi)) begin
			sum_sat = sum[ACC_BITS-1:0];
		end else if (sum[ADD_W-1]) begin
			sum_sat = ACC_MIN;
		end else begin
			sum_sat = ACC_MAX;
		end
		neg = sum_sat[ACC_BITS-1];
		act_val = sum_sat;
		if (cfg.act_mode == acrq_pkg::ACT_RELU && neg) begin
			act_val = '0;
		end
		sh_base = cfg.output_shift[6] ? 7'd0 : {1'b0, cfg.output_shift[5:0]};
		sh_val = sh_base;
		if (cfg.act_mode == acrq_pkg::ACT_LEAKY && neg) begin
			sh_val = sh_base + acrq_pkg::LEAKY_EXTRA_SHIFT;
		end
	end

	// stage 3 logic: shift with one guard bit kept as the rounding bit
	logic signed [ACC_BITS:0] t_val;

	always_comb begin
		t_val = $signed({x_s2, 1'b0}) >>> sh_s2;
	end

	// stage 4 logic: round half up, saturate to int16
	logic signed [ACC_BITS:0] rnd;
	logic [ACC_BITS-15:0]     rnd_hi;
	logic [15:0]              sat16;

	always_comb begin
		rnd = ($signed(t_s3) >>> 1) + $signed({{ACC_BITS{1'b0}}, t_s3[0]});
		rnd_hi = rnd[ACC_BITS:15];
		if ((&rnd_hi) || !(|rnd_hi)) begin
			sat16 = rnd[15:0];
		end else if (rnd[ACC_BITS]) begin
			sat16 = 16'h8000;
		end else begin
			sat16 = 16'h7fff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			acc_s1 <= acc_sat;
			bias_s1 <= bias_sc;
		end
		if (v_s1) begin
			x_s2 <= act_val;
			sh_s2 <= sh_val;
		end
		if (v_s2) begin
			t_s3 <= t_val;
		end
		if (v_s3) begin
			out_s4 <= sat16;
		end
	end

	assign out_valid = v_s4;
	assign out_value = out_s4;

endmodule

>>> rtl/accumulator_requantize_int16.sv
// accumulator_requantize_int16: top level with configuration registers.
// Depends on acrq_pkg and acrq_datapath.
//
// Usage:
//   Input channel: a beat (acc_sum, bias_value) is taken on every rising
//   edge with start high and busy low. busy is never raised, so a new beat
//   may be offered in every cycle.
//   Result channel: result_valid is high for one cycle with out_value; the
//   receiver must take it then, it cannot hold results off.
//   A beat passes through four register stages (input saturate and bias
//   scale, bias add and activation, rounding shift, int16 saturation);
//   throughput is one beat per cycle.
//   Configuration: cfg_wr_en with cfg_index 0 (activation mode), 1 (output
//   shift) or 2 (bias shift) writes cfg_data at the edge; index 3 is ignored.
//   Write only while no beats are in flight.
//   Reset clears the configuration registers and valid flags to 0 and empties
//   the pipeline; no result appears until a new beat is accepted.
module accumulator_requantize_int16 #(
	parameter int ACC_BITS = 40
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [63:0]                   acc_sum,
	input  logic signed [15:0]                   bias_value,
	output logic                                 result_valid,
	output logic signed [15:0]                   out_value,
	input  logic                                 cfg_wr_en,
	input  logic [acrq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [acrq_pkg::CFG_DATA_W-1:0]      cfg_data
);

	acrq_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				acrq_pkg::REG_ACT_MODE: cfg_q.act_mode <= cfg_data[1:0];
				acrq_pkg::REG_OUT_SHIFT: cfg_q.output_shift <= cfg_data[6:0];
				acrq_pkg::REG_BIAS_SHIFT: cfg_q.bias_shift <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	acrq_datapath #(
		.ACC_BITS(ACC_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start && !busy),
		.acc_sum    (acc_sum),
		.bias_value (bias_value),
		.cfg        (cfg_q),
		.out_valid  (result_valid),
		.out_value  (out_value)
	);

endmodule

>>> tb/accumulator_requantize_int16_tb.sv
// Self-checking testbench for accumulator_requantize_int16: directed corners, then random beats
// across many register settings, checked against an in-bench requantization predictor.
// Depends on acrq_pkg and the accumulator_requantize_int16 RTL.
module accumulator_requantize_int16_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [acrq_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam longint ACC_HI = (64'sd1 <<< 39) - 1;
	localparam longint ACC_LO = -(64'sd1 <<< 39);

	class requant_scoreboard;
		logic [1:0] act_mode;
		logic [6:0] out_shift;
		logic [5:0] bias_shift;
		logic signed [15:0] expected_out[$];
		int errors;

		function new();
			act_mode = acrq_pkg::ACT_NONE;
			out_shift = '0;
			bias_shift = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [acrq_pkg::CFG_IDX_W-1:0] idx,
				logic [acrq_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				acrq_pkg::REG_ACT_MODE: act_mode = data[1:0];
				acrq_pkg::REG_OUT_SHIFT: out_shift = data[6:0];
				acrq_pkg::REG_BIAS_SHIFT: bias_shift = data[5:0];
				default: ;
			endcase
		endfunction

		function longint sat_acc(longint x);
			if (x > ACC_HI) return ACC_HI;
			if (x < ACC_LO) return ACC_LO;
			return x;
		endfunction

		function longint asr(longint x, int unsigned s);
			if (s > 63) s = 63;
			return x >>> s;
		endfunction

		function longint round_rshift(longint x, int unsigned s);
			longint rbit;
			if (s == 0) return x;
			rbit = asr(x, s - 1) & 64'sd1;
			return asr(x, s) + rbit;
		endfunction

		function logic signed [15:0] requant_predict(logic signed [63:0] acc,
				logic signed [15:0] bias);
			longint s, b, bs, os;
			int unsigned sh;
			s = sat_acc(acc);
			b = bias;
			bs = $signed(bias_shift);
			if (bs < 0) b = b <<< (-bs);
			else if (bs > 0) b = b >>> bs;
			s = sat_acc(s + b);
			if (act_mode == acrq_pkg::ACT_RELU && s < 0) s = 0;
			os = $signed(out_shift);
			if (os < 0) os = 0;
			sh = int'(os);
			if (act_mode == acrq_pkg::ACT_LEAKY && s < 0) sh += 3;
			s = round_rshift(s, sh);
			if (s > 32767) s = 32767;
			if (s < -32768) s = -32768;
			return s[15:0];
		endfunction

		function void note_beat(logic signed [63:0] acc, logic signed [15:0] bias);
			expected_out.push_back(requant_predict(acc, bias));
		endfunction

		function void check_out(logic signed [15:0] actual);
			logic signed [15:0] exp_v;
			if (expected_out.size() == 0) begin
				$error("out_value: no result expected, actual %0d", actual);
				errors++;
				return;
			end
			exp_v = expected_out.pop_front();
			if (actual !== exp_v) begin
				$error("out_value: expected %0d, actual %0d", exp_v, actual);
				errors++;
			end
		endfunction

		function int pending();
			return expected_out.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [63:0] acc_sum;
	logic signed [15:0] bias_value;
	logic result_valid;
	logic signed [15:0] out_value;
	logic cfg_wr_en;
	logic [acrq_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [acrq_pkg::CFG_DATA_W-1:0] cfg_data;

	requant_scoreboard sb;
	bit no_gaps;

	accumulator_requantize_int16 uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.acc_sum(acc_sum),
		.bias_value(bias_value),
		.result_valid(result_valid),
		.out_value(out_value),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en) sb.write_reg(cfg_index, cfg_data);
			if (start && !busy) sb.note_beat(acc_sum, bias_value);
			if (result_valid) sb.check_out(out_value);
		end
	end

	task automatic send_beat(input logic signed [63:0] a, input logic signed [15:0] b);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		acc_sum <= a;
		bias_value <= b;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic program_cfg(input logic [6:0] act_d, input logic [6:0] osh_d,
			input logic [6:0] bsh_d);
		drain();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= acrq_pkg::REG_ACT_MODE;
		cfg_data <= act_d;
		@(negedge clk);
		cfg_index <= acrq_pkg::REG_OUT_SHIFT;
		cfg_data <= osh_d;
		@(negedge clk);
		cfg_index <= acrq_pkg::REG_BIAS_SHIFT;
		cfg_data <= bsh_d;
		if ($urandom_range(0, 3) == 0) begin
			@(negedge clk);
			cfg_index <= REG_UNUSED;
			cfg_data <= 7'($urandom);
		end
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic signed [63:0] rand_acc();
		logic signed [63:0] r;
		int w;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: ;
			1: r = (r[63] ? ACC_LO : ACC_HI) + 64'($signed(r[7:0]));
			default: begin
				w = $urandom_range(1, 48);
				r = r >>> (64 - w);
			end
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] rand_bias();
		logic signed [15:0] r;
		r = 16'($urandom);
		case ($urandom_range(0, 9))
			0: r = 16'sh7fff;
			1: r = -16'sh8000;
			2, 3: r = r >>> $urandom_range(4, 15);
			default: ;
		endcase
		return r;
	endfunction

	initial begin
		logic [1:0] act;
		logic [6:0] osh_d, bsh_d;
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		acc_sum = '0;
		bias_value = '0;
		cfg_wr_en = 1'b0;
		cfg_index = acrq_pkg::REG_ACT_MODE;
		cfg_data = '0;
		no_gaps = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings first: linear, no shifts
		send_beat(64'sh7fffffffffffffff, 16'sd0);
		send_beat(64'sh8000000000000000, 16'sd0);
		send_beat(64'sd0, 16'sh7fff);
		send_beat(-64'sd1, -16'sh8000);
		send_beat(ACC_HI, 16'sh7fff);

		program_cfg(7'(acrq_pkg::ACT_RELU), 7'(4), 7'(-24));
		send_beat(-64'sd1000, 16'sd0);
		send_beat(64'sd0, -16'sh8000);
		send_beat(64'sd100, 16'sh7fff);
		send_beat(ACC_HI, 16'sh7fff);

		program_cfg(7'(acrq_pkg::ACT_LEAKY), 7'(5), 7'(24));
		send_beat(-64'sd100, -16'sd1);
		send_beat(-64'sd1048576, 16'sd0);
		send_beat(64'sd1000, 16'sh7fff);
		send_beat(-64'sd8, 16'sd0);

		program_cfg(7'(ACT_UNUSED), 7'(-16), 7'(-32));
		send_beat(64'sd12345, -16'sh8000);
		send_beat(-64'sd5, 16'sd1);

		program_cfg(7'(acrq_pkg::ACT_LEAKY), 7'(63), 7'(31));
		send_beat(-64'sd1, 16'sd0);
		send_beat(ACC_LO, -16'sh8000);
		send_beat(64'sh7fffffffffffffff, 16'sh7fff);

		program_cfg(7'(acrq_pkg::ACT_NONE), 7'(16), 7'(1));
		send_beat(64'sd32768, 16'sd0);
		send_beat(-64'sd32768, 16'sd0);
		send_beat(64'sd98304, -16'sd1);

		for (int ph = 0; ph < 22; ph++) begin
			act = ($urandom_range(0, 9) == 0) ? ACT_UNUSED : 2'($urandom_range(0, 2));
			osh_d = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'(int'($urandom_range(0, 56)) - 16);
			bsh_d = ($urandom_range(0, 4) == 0) ? 7'($urandom)
				: {1'($urandom), 6'(int'($urandom_range(0, 48)) - 24)};
			case (ph)
				0: begin osh_d = 7'(-64); bsh_d = 7'(-32); end
				1: begin osh_d = 7'(63); bsh_d = 7'(31); end
				2: begin osh_d = 7'(40); bsh_d = 7'(24); end
				3: begin osh_d = 7'(-16); bsh_d = 7'(-24); end
				default: ;
			endcase
			if (ph < 4) act = 2'(ph);
			program_cfg({5'($urandom), act}, osh_d, bsh_d);
			no_gaps = (ph % 3 == 0);
			for (int i = 0; i < 25; i++) begin
				if ($urandom_range(0, 7) == 0) no_gaps = !no_gaps;
				send_beat(rand_acc(), rand_bias());
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("** accumulator_requantize_int16: PASSED **");
		end else begin
			$display("** accumulator_requantize_int16: FAILED **");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("** accumulator_requantize_int16: FAILED **");
		$finish;
	end

endmodule
